FILE: rtl/ftr_pkg.sv
// ----------------------------------------------------------------------------
// ftr_pkg
// Shared types and codes of the framed transfer receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ftr_pkg;

  localparam int FrameBytesDefault = 128;

  // result queue between parser and emitter
  localparam int QDepth = 4;
  localparam int QIdxW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // input commands
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_NEW  = 2'd1;
  localparam logic [1:0] CMD_FAIL = 2'd2;

  // result destinations
  localparam logic [1:0] DEST_ACK    = 2'd0;
  localparam logic [1:0] DEST_CMD    = 2'd1;
  localparam logic [1:0] DEST_DATA   = 2'd2;
  localparam logic [1:0] DEST_STATUS = 2'd3;

  // session status
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // frame types and emitted codes
  localparam logic [7:0] TYPE_START = 8'hA0;
  localparam logic [7:0] TYPE_DATA  = 8'hA1;
  localparam logic [7:0] TYPE_MID   = 8'hA2;
  localparam logic [7:0] TYPE_END   = 8'hA3;
  localparam logic [7:0] CODE_START = 8'hA5;
  localparam logic [7:0] CODE_MID   = 8'hA7;
  localparam logic [7:0] CODE_END   = 8'hA8;

  typedef enum logic [6:0] {
    PH_TYPE    = 7'b0000001,
    PH_START   = 7'b0000010,
    PH_LEN_HI  = 7'b0000100,
    PH_LEN_LO  = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_MID     = 7'b0100000,
    PH_END     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_in;
  } ftr_in_t;

  typedef struct packed {
    logic [1:0] dest;
    logic [7:0] byte_value;
    logic [1:0] status;
    logic       last;
  } ftr_out_t;

  // all results caused by one input item
  typedef struct packed {
    logic     two;
    ftr_out_t first;
    ftr_out_t second;
  } ftr_entry_t;

endpackage

`default_nettype wire

FILE: rtl/ftr_parse.sv
// ----------------------------------------------------------------------------
// ftr_parse
// Front end: parses one stream byte per cycle while accept is high and builds its result entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ftr_parse #(
  parameter int FRAME_BYTES = ftr_pkg::FrameBytesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire ftr_pkg::ftr_in_t   item,
  output logic                    ent_push,
  output ftr_pkg::ftr_entry_t     ent
);

  ftr_pkg::phase_t phase, phase_next;
  logic        started, started_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] running_sum, running_sum_next;
  logic        fwd_en, fwd_en_next;
  logic [1:0]  sess, sess_next;

  logic [1:0]  nres;
  logic [1:0]  d0, d1;
  logic [7:0]  v0, v1;
  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] dec;
  logic [31:0] shifted;

  assign b       = item.byte_in;
  assign len     = {field_shift[7:0], b};
  assign dec     = bytes_left - 16'd1;
  assign shifted = {field_shift[23:0], b};

  always_comb begin
    phase_next       = phase;
    started_next     = started;
    bytes_left_next  = bytes_left;
    field_shift_next = field_shift;
    running_sum_next = running_sum;
    fwd_en_next      = fwd_en;
    sess_next        = sess;
    nres = 2'd0;
    d0 = ftr_pkg::DEST_STATUS;
    v0 = 8'h00;
    d1 = ftr_pkg::DEST_STATUS;
    v1 = 8'h00;
    if (item.cmd == ftr_pkg::CMD_NEW) begin
      phase_next       = ftr_pkg::PH_TYPE;
      started_next     = 1'b0;
      bytes_left_next  = '0;
      field_shift_next = '0;
      running_sum_next = '0;
      fwd_en_next      = 1'b0;
      sess_next        = ftr_pkg::ST_RUN;
    end else if (sess == ftr_pkg::ST_RUN) begin
      if (item.cmd == ftr_pkg::CMD_FAIL) begin
        sess_next = ftr_pkg::ST_ERR;
        nres      = 2'd1;
      end else if (item.cmd == ftr_pkg::CMD_BYTE) begin
        unique case (phase)
          ftr_pkg::PH_TYPE: begin
            if (b == ftr_pkg::TYPE_START) begin
              if (started) begin
                sess_next = ftr_pkg::ST_ERR;
                nres      = 2'd1;
              end else begin
                bytes_left_next = 16'd8;
                phase_next      = ftr_pkg::PH_START;
              end
            end else if (b == ftr_pkg::TYPE_DATA) begin
              phase_next = ftr_pkg::PH_LEN_HI;
            end else if (b == ftr_pkg::TYPE_MID) begin
              bytes_left_next = 16'd2;
              phase_next      = ftr_pkg::PH_MID;
            end else if (b == ftr_pkg::TYPE_END) begin
              bytes_left_next  = 16'd4;
              field_shift_next = '0;
              phase_next       = ftr_pkg::PH_END;
            end else begin
              sess_next = ftr_pkg::ST_ERR;
              nres      = 2'd1;
            end
          end
          ftr_pkg::PH_START: begin
            bytes_left_next = dec;
            if (dec == 16'd0) begin
              nres = 2'd2;
              d0 = ftr_pkg::DEST_CMD;
              v0 = ftr_pkg::CODE_START;
              d1 = ftr_pkg::DEST_ACK;
              v1 = ftr_pkg::TYPE_START;
              started_next = 1'b1;
              phase_next   = ftr_pkg::PH_TYPE;
            end
          end
          ftr_pkg::PH_LEN_HI: begin
            field_shift_next = {24'd0, b};
            phase_next       = ftr_pkg::PH_LEN_LO;
          end
          ftr_pkg::PH_LEN_LO: begin
            field_shift_next = {16'd0, len};
            if (len == 16'd0) begin
              phase_next = ftr_pkg::PH_TYPE;
            end else begin
              bytes_left_next = len;
              fwd_en_next     = ({1'b0, len} < 17'(FRAME_BYTES));
              nres = 2'd1;
              d0   = ftr_pkg::DEST_CMD;
              v0   = ftr_pkg::TYPE_DATA;
              phase_next = ftr_pkg::PH_PAYLOAD;
            end
          end
          ftr_pkg::PH_PAYLOAD: begin
            running_sum_next = running_sum + {24'd0, b};
            if (fwd_en) begin
              nres = 2'd1;
              d0   = ftr_pkg::DEST_DATA;
              v0   = b;
            end
            bytes_left_next = dec;
            if (dec == 16'd0) phase_next = ftr_pkg::PH_TYPE;
          end
          ftr_pkg::PH_MID: begin
            bytes_left_next = dec;
            if (dec == 16'd0) begin
              nres = 2'd2;
              d0 = ftr_pkg::DEST_ACK;
              v0 = ftr_pkg::TYPE_MID;
              d1 = ftr_pkg::DEST_CMD;
              v1 = ftr_pkg::CODE_MID;
              started_next = 1'b1;
              phase_next   = ftr_pkg::PH_TYPE;
            end
          end
          ftr_pkg::PH_END: begin
            field_shift_next = shifted;
            bytes_left_next  = dec;
            if (dec == 16'd0) begin
              phase_next = ftr_pkg::PH_TYPE;
              if (shifted != running_sum) begin
                sess_next = ftr_pkg::ST_ERR;
                nres      = 2'd1;
              end else begin
                nres = 2'd2;
                d0 = ftr_pkg::DEST_CMD;
                v0 = ftr_pkg::CODE_END;
                d1 = ftr_pkg::DEST_ACK;
                v1 = ftr_pkg::TYPE_END;
                sess_next = ftr_pkg::ST_DONE;
              end
            end
          end
          default: phase_next = ftr_pkg::PH_TYPE;
        endcase
      end
    end
  end

  always_comb begin
    ent.two               = (nres == 2'd2);
    ent.first.dest        = d0;
    ent.first.byte_value  = v0;
    ent.first.status      = sess_next;
    ent.first.last        = (nres != 2'd2);
    ent.second.dest       = d1;
    ent.second.byte_value = v1;
    ent.second.status     = sess_next;
    ent.second.last       = 1'b1;
  end

  assign ent_push = accept && (nres != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ftr_pkg::PH_TYPE;
      started     <= 1'b0;
      bytes_left  <= '0;
      field_shift <= '0;
      running_sum <= '0;
      fwd_en      <= 1'b0;
      sess        <= ftr_pkg::ST_RUN;
    end else if (accept) begin
      phase       <= phase_next;
      started     <= started_next;
      bytes_left  <= bytes_left_next;
      field_shift <= field_shift_next;
      running_sum <= running_sum_next;
      fwd_en      <= fwd_en_next;
      sess        <= sess_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ftr_fifo.sv
// ----------------------------------------------------------------------------
// ftr_fifo
// Short queue of result entries between parser and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ftr_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire ftr_pkg::ftr_entry_t wr_data,
  input  wire logic                rd_en,
  output logic                     full,
  output logic                     valid,
  output ftr_pkg::ftr_entry_t      rd_data
);

  ftr_pkg::ftr_entry_t mem [ftr_pkg::QDepth];
  logic [ftr_pkg::QIdxW-1:0] wr_ptr, rd_ptr;
  logic [ftr_pkg::QCntW-1:0] count;
  logic do_wr, do_rd;

  assign full    = (count == ftr_pkg::QCntW'(ftr_pkg::QDepth));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ftr_emit.sv
// ----------------------------------------------------------------------------
// ftr_emit
// Back end: holds one entry and hands out its results one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ftr_emit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire ftr_pkg::ftr_entry_t q_data,
  output logic                     q_pop,
  output logic                     empty,
  input  wire logic                pop,
  output ftr_pkg::ftr_out_t        result
);

  logic                have;
  logic                idx;
  ftr_pkg::ftr_entry_t ent;
  logic                taken;
  logic                release_ent;

  assign empty       = !have;
  assign result      = idx ? ent.second : ent.first;
  assign taken       = pop && have;
  assign release_ent = taken && (idx || !ent.two);
  assign q_pop       = q_valid && (!have || release_ent);

  always_ff @(posedge clk) begin
    if (q_pop) ent <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= 1'b0;
    end else if (q_pop) begin
      have <= 1'b1;
      idx  <= 1'b0;
    end else if (release_ent) begin
      have <= 1'b0;
      idx  <= 1'b0;
    end else if (taken) begin
      // first of a pair went out
      idx <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/framed_transfer_receiver.sv
// ----------------------------------------------------------------------------
// framed_transfer_receiver
// Typed-frame byte stream parser with host ack and downstream outputs.
// ----------------------------------------------------------------------------
// Input channel: drive item (cmd, byte_in) with push; a transfer happens when
// push is high and full is low. One item per cycle is taken while full stays low.
// Result channel: while empty is low, result holds the oldest result; it is
// taken when pop is high. An item yields zero, one or two results, the last
// one flagged by result.last.
// A result passes through the queue and then the emitter's entry register
// before it shows on the result port. Throughput: one item per cycle while
// full is low; results leave at one per cycle while pop is high, each result
// of a pair as its own transfer. A four-entry queue between the parser and
// the emitter absorbs bursts; full rises only when that queue is full.
// Reset (rst, synchronous) clears the parser, the queue and the output stage;
// cmd 1 on the input starts a new session and clears the parser only.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_transfer_receiver #(
  parameter int FRAME_BYTES = ftr_pkg::FrameBytesDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire ftr_pkg::ftr_in_t  item,
  output logic                   empty,
  input  wire logic              pop,
  output ftr_pkg::ftr_out_t      result
);

  logic                accept;
  logic                ent_push;
  ftr_pkg::ftr_entry_t ent;
  logic                q_valid;
  logic                q_pop;
  ftr_pkg::ftr_entry_t q_data;

  assign accept = push && !full;

  ftr_parse #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .ent_push(ent_push),
    .ent     (ent)
  );

  ftr_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (ent_push),
    .wr_data(ent),
    .rd_en  (q_pop),
    .full   (full),
    .valid  (q_valid),
    .rd_data(q_data)
  );

  ftr_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_data (q_data),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

FILE: rtl/ftr_checker.sv
// ----------------------------------------------------------------------------
// ftr_checker
// Port-level checks of the framed transfer receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module ftr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              push,
  input wire logic              full,
  input wire ftr_pkg::ftr_in_t  item,
  input wire logic              empty,
  input wire logic              pop,
  input wire ftr_pkg::ftr_out_t result
);

  logic unused_item;
  assign unused_item = ^item;

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // status-only results carry a zero byte and an error status
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.dest == ftr_pkg::DEST_STATUS) |->
      (result.byte_value == 8'h00 && result.status == ftr_pkg::ST_ERR))
    else $error("malformed status-only result");

  // the second result of a pair follows at once with the same status
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last) |=>
      (!empty && result.status == $past(result.status)))
    else $error("pair of results broken up");

  // the queue only fills up on an input transfer
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without an input transfer");

  // session status is never the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.status != 2'd3 && unused_item == unused_item))
    else $error("invalid status code");

endmodule

bind framed_transfer_receiver ftr_checker u_ftr_checker (
  .clk   (clk),
  .rst   (rst),
  .push  (push),
  .full  (full),
  .item  (item),
  .empty (empty),
  .pop   (pop),
  .result(result)
);

`default_nettype wire

FILE: tb/ftr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ftr_tb_checker
// Watches both queue ports of the frame parser, predicts the results of every
// accepted input transfer and compares each result transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------

module ftr_tb_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  ftr_pkg::ftr_in_t  item,
  input  logic              empty,
  input  logic              pop,
  input  ftr_pkg::ftr_out_t result,
  output int                errors,
  output int                outstanding
);

  localparam int FrameLimit = ftr_pkg::FrameBytesDefault;

  // parser state as seen by the predictor
  ftr_pkg::phase_t phase;
  logic            started;
  logic [15:0]     left;
  logic [31:0]     field_acc;
  logic [31:0]     payload_sum;
  logic            fwd_on;
  logic [1:0]      session;

  ftr_pkg::ftr_out_t pending_results[$];
  int                mismatches = 0;

  assign errors = mismatches;

  function automatic ftr_pkg::ftr_out_t make_result(logic [1:0] dest, logic [7:0] value);
    make_result = '{dest: dest, byte_value: value, status: ftr_pkg::ST_RUN, last: 1'b0};
  endfunction

  task clear_session();
    phase       = ftr_pkg::PH_TYPE;
    started     = 1'b0;
    left        = '0;
    field_acc   = '0;
    payload_sum = '0;
    fwd_on      = 1'b0;
    session     = ftr_pkg::ST_RUN;
  endtask

  task parse_stream_item(input ftr_pkg::ftr_in_t it);
    ftr_pkg::ftr_out_t res [2];
    int                n;
    logic              err;
    logic [15:0]       len;
    logic [7:0]        b;
    n   = 0;
    err = 1'b0;
    b   = it.byte_in;
    if (it.cmd == ftr_pkg::CMD_NEW) begin
      clear_session();
      return;
    end
    // once the session has ended everything but a new session is dropped
    if (session != ftr_pkg::ST_RUN) return;
    if (it.cmd == ftr_pkg::CMD_FAIL) begin
      err = 1'b1;
    end else if (it.cmd == ftr_pkg::CMD_BYTE) begin
      case (phase)
        ftr_pkg::PH_TYPE: begin
          case (b)
            ftr_pkg::TYPE_START: begin
              if (started) err = 1'b1;
              else begin
                left  = 16'd8;
                phase = ftr_pkg::PH_START;
              end
            end
            ftr_pkg::TYPE_DATA: phase = ftr_pkg::PH_LEN_HI;
            ftr_pkg::TYPE_MID: begin
              left  = 16'd2;
              phase = ftr_pkg::PH_MID;
            end
            ftr_pkg::TYPE_END: begin
              left      = 16'd4;
              field_acc = '0;
              phase     = ftr_pkg::PH_END;
            end
            default: err = 1'b1;
          endcase
        end
        ftr_pkg::PH_START: begin
          left = left - 16'd1;
          if (left == 0) begin
            res[0]  = make_result(ftr_pkg::DEST_CMD, ftr_pkg::CODE_START);
            res[1]  = make_result(ftr_pkg::DEST_ACK, ftr_pkg::TYPE_START);
            n       = 2;
            started = 1'b1;
            phase   = ftr_pkg::PH_TYPE;
          end
        end
        ftr_pkg::PH_LEN_HI: begin
          field_acc = {24'd0, b};
          phase     = ftr_pkg::PH_LEN_LO;
        end
        ftr_pkg::PH_LEN_LO: begin
          len       = {field_acc[7:0], b};
          field_acc = {16'd0, len};
          if (len == 0) phase = ftr_pkg::PH_TYPE;
          else begin
            left   = len;
            fwd_on = (len < FrameLimit);
            res[0] = make_result(ftr_pkg::DEST_CMD, ftr_pkg::TYPE_DATA);
            n      = 1;
            phase  = ftr_pkg::PH_PAYLOAD;
          end
        end
        ftr_pkg::PH_PAYLOAD: begin
          payload_sum = payload_sum + {24'd0, b};
          if (fwd_on) begin
            res[0] = make_result(ftr_pkg::DEST_DATA, b);
            n      = 1;
          end
          left = left - 16'd1;
          if (left == 0) phase = ftr_pkg::PH_TYPE;
        end
        ftr_pkg::PH_MID: begin
          left = left - 16'd1;
          if (left == 0) begin
            res[0]  = make_result(ftr_pkg::DEST_ACK, ftr_pkg::TYPE_MID);
            res[1]  = make_result(ftr_pkg::DEST_CMD, ftr_pkg::CODE_MID);
            n       = 2;
            started = 1'b1;
            phase   = ftr_pkg::PH_TYPE;
          end
        end
        ftr_pkg::PH_END: begin
          field_acc = {field_acc[23:0], b};
          left      = left - 16'd1;
          if (left == 0) begin
            phase = ftr_pkg::PH_TYPE;
            if (field_acc != payload_sum) err = 1'b1;
            else begin
              res[0]  = make_result(ftr_pkg::DEST_CMD, ftr_pkg::CODE_END);
              res[1]  = make_result(ftr_pkg::DEST_ACK, ftr_pkg::TYPE_END);
              n       = 2;
              session = ftr_pkg::ST_DONE;
            end
          end
        end
        default: phase = ftr_pkg::PH_TYPE;
      endcase
    end else begin
      return;
    end
    if (err) begin
      session = ftr_pkg::ST_ERR;
      res[0]  = make_result(ftr_pkg::DEST_STATUS, 8'h00);
      n       = 1;
    end
    for (int k = 0; k < n; k++) begin
      res[k].status = session;
      res[k].last   = (k == n - 1);
      pending_results.push_back(res[k]);
    end
  endtask

  always @(posedge clk) begin
    ftr_pkg::ftr_out_t want;
    if (rst) begin
      clear_session();
      pending_results.delete();
    end else begin
      if (push && !full) parse_stream_item(item);
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result dest=%0d byte=%02h status=%0d last=%0d",
                     $time, result.dest, result.byte_value, result.status, result.last);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result.dest !== want.dest || result.byte_value !== want.byte_value ||
              result.status !== want.status || result.last !== want.last) begin
            if (mismatches < 10)
              $display({"%0t: result mismatch: expected dest=%0d byte=%02h status=%0d ",
                        "last=%0d, got dest=%0d byte=%02h status=%0d last=%0d"},
                       $time, want.dest, want.byte_value, want.status, want.last,
                       result.dest, result.byte_value, result.status, result.last);
            mismatches++;
          end
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/tb_framed_transfer_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_transfer_receiver
// Drives directed and random frame streams (well-formed sessions, broken
// frames, aborts, noise) into the parser with random gaps and result stalls,
// including one long result hold-off that fills the block; ftr_tb_checker
// does the prediction and comparison.
// ----------------------------------------------------------------------------

module tb_framed_transfer_receiver;

  logic              clk;
  logic              rst  = 1'b1;
  logic              push = 1'b0;
  logic              pop  = 1'b0;
  ftr_pkg::ftr_in_t  item = '0;
  logic              full;
  logic              empty;
  ftr_pkg::ftr_out_t result;
  int                errors;
  int                outstanding;

  int          items_sent    = 0;
  int          tx_quiet      = 0;
  int          rx_quiet      = 0;
  int          hold_requests = 0;
  int          holds_done    = 0;
  logic [31:0] stream_sum    = '0;

  framed_transfer_receiver uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  ftr_tb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // one input transfer; push stays high into the next call when it has no gap
  task send(input logic [1:0] c, input logic [7:0] b);
    int gap;
    if (tx_quiet > 0) begin
      gap = 0;
      tx_quiet--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 29) == 0) tx_quiet = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{cmd: c, byte_in: b};
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task new_session();
    send(ftr_pkg::CMD_NEW, 8'($urandom_range(0, 255)));
    stream_sum = '0;
  endtask

  task send_start();
    send(ftr_pkg::CMD_BYTE, ftr_pkg::TYPE_START);
    repeat (8) send(ftr_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
  endtask

  task send_mid();
    send(ftr_pkg::CMD_BYTE, ftr_pkg::TYPE_MID);
    repeat (2) send(ftr_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
  endtask

  task send_data(input logic [15:0] len);
    logic [7:0] b;
    send(ftr_pkg::CMD_BYTE, ftr_pkg::TYPE_DATA);
    send(ftr_pkg::CMD_BYTE, len[15:8]);
    send(ftr_pkg::CMD_BYTE, len[7:0]);
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      stream_sum = stream_sum + {24'd0, b};
      send(ftr_pkg::CMD_BYTE, b);
    end
  endtask

  task send_end(input logic good);
    logic [31:0] sum;
    sum = good ? stream_sum : stream_sum ^ (32'd1 << $urandom_range(0, 31));
    send(ftr_pkg::CMD_BYTE, ftr_pkg::TYPE_END);
    send(ftr_pkg::CMD_BYTE, sum[31:24]);
    send(ftr_pkg::CMD_BYTE, sum[23:16]);
    send(ftr_pkg::CMD_BYTE, sum[15:8]);
    send(ftr_pkg::CMD_BYTE, sum[7:0]);
  endtask

  // result side
  initial begin
    int stall;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (rx_quiet > 0) begin
        stall = 0;
        rx_quiet--;
      end else begin
        stall = $urandom_range(0, 14);
        if ($urandom_range(0, 19) == 0) rx_quiet = $urandom_range(10, 40);
      end
      if (holds_done < hold_requests) begin
        holds_done++;
        stall = 150;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    int          frames;
    int          pick;
    logic [15:0] len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // data before any start, one forwarded byte, then zero length
    new_session();
    send_data(16'd1);
    send_data(16'd0);
    send_start();
    // second start is an error; later bytes, failure and unused cmd are dropped
    send(ftr_pkg::CMD_BYTE, ftr_pkg::TYPE_START);
    send(ftr_pkg::CMD_BYTE, 8'h00);
    send(ftr_pkg::CMD_FAIL, 8'hFF);
    send(2'd3, 8'hFF);
    // mid marks the session started, so a start after it fails
    new_session();
    send_mid();
    send(ftr_pkg::CMD_BYTE, ftr_pkg::TYPE_START);
    new_session();
    send(ftr_pkg::CMD_BYTE, 8'h00);
    new_session();
    send(ftr_pkg::CMD_FAIL, 8'h00);
    // longest length, aborted by a new session
    new_session();
    send(ftr_pkg::CMD_BYTE, ftr_pkg::TYPE_DATA);
    send(ftr_pkg::CMD_BYTE, 8'hFF);
    send(ftr_pkg::CMD_BYTE, 8'hFF);
    send(ftr_pkg::CMD_BYTE, 8'h5A);
    new_session();
    send_data(16'd2);
    send_end(1'b0);
    new_session();
    send_data(16'd1);
    send_end(1'b1);

    // long result hold-off with a back-to-back burst behind it
    hold_requests++;
    tx_quiet = 300;
    new_session();
    send_start();
    send_data(16'd100);
    send_end(1'b1);
    tx_quiet = 0;

    while (items_sent < 1000) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        new_session();
        if ($urandom_range(0, 9) < 8) send_start();
        frames = $urandom_range(1, 4);
        repeat (frames) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) len = 16'($urandom_range(1, 16));
            else if (pick < 7) len = 16'd0;
            else if (pick < 8) len = 16'($urandom_range(120, 135));
            else len = 16'($urandom_range(17, 60));
            send_data(len);
          end else if (pick < 9) begin
            send_mid();
          end else begin
            send_start();
          end
          if ($urandom_range(0, 19) == 0)
            send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) < 8) send_end($urandom_range(0, 6) != 0);
        else send(ftr_pkg::CMD_FAIL, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6))
          send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
